>>> hdl/mlqas_pkg.sv
// ----------------------------------------------------------------------------
// mlqas_pkg
// Shared widths, operation codes and the command and status bundles of the
// multilevel ready-queue scheduler.
// ----------------------------------------------------------------------------
package mlqas_pkg;

    // fixed field widths
    localparam int ID_W   = 3;
    localparam int OP_W   = 2;
    localparam int PRIO_W = 2;

    // default sizes
    localparam int DEF_NUM_PROCESSES = 8;
    localparam int DEF_NUM_LEVELS    = 4;

    // operation codes
    localparam logic [OP_W-1:0] OP_SCHED = 2'd0;
    localparam logic [OP_W-1:0] OP_RESET = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // level selection codes
    localparam logic [1:0] LVL_CUR   = 2'd0;
    localparam logic [1:0] LVL_NEXT  = 2'd1;
    localparam logic [1:0] LVL_PRIO  = 2'd2;
    localparam logic [1:0] LVL_FIRST = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic       capture;
        logic       clear;
        logic [1:0] lvl_sel;
        logic       lvl_clr;
        logic       lvl_inc;
        logic       pop;
        logic       push_rd;
        logic       push_id;
        logic       rm_init;
        logic       rm_rd;
        logic       rm_chk;
        logic       rm_commit;
        logic       pick_mark;
        logic       out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            id_ok;
        logic            last_lvl;
        logic            nonempty_next;
        logic            full_cur;
        logic            rm_done;
        logic            out_free;
    } status_t;

endpackage

>>> hdl/mlqas_ram.sv
// ----------------------------------------------------------------------------
// mlqas_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlqas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/mlqas_ctrl.sv
// ----------------------------------------------------------------------------
// mlqas_ctrl
// Sequencer of the scheduler: walks aging, re-queue, pick and removal steps
// and drives the datapath through a command bundle.
// ----------------------------------------------------------------------------
module mlqas_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  mlqas_pkg::status_t status,
    output mlqas_pkg::cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DISPATCH = 4'd1;
    localparam logic [3:0] ST_AGE_CHK  = 4'd2;
    localparam logic [3:0] ST_AGE_RD   = 4'd3;
    localparam logic [3:0] ST_AGE_WR   = 4'd4;
    localparam logic [3:0] ST_PUSH     = 4'd5;
    localparam logic [3:0] ST_PICK     = 4'd6;
    localparam logic [3:0] ST_SEND     = 4'd7;
    localparam logic [3:0] ST_RM_RD    = 4'd8;
    localparam logic [3:0] ST_RM_CHK   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.lvl_sel = mlqas_pkg::LVL_CUR;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.op)
                    mlqas_pkg::OP_SCHED:
                    begin
                        cmd.lvl_clr = 1'b1;
                        state_next  = ST_AGE_CHK;
                    end
                    mlqas_pkg::OP_RESET:
                    begin
                        if (status.id_ok)
                        begin
                            cmd.lvl_clr = 1'b1;
                            cmd.rm_init = 1'b1;
                            state_next  = ST_RM_RD;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    mlqas_pkg::OP_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            // aging: move head of level+1 to tail of level
            ST_AGE_CHK:
            begin
                if (status.last_lvl)
                begin
                    state_next = ST_PUSH;
                end
                else if (status.nonempty_next && !status.full_cur)
                begin
                    state_next = ST_AGE_RD;
                end
                else
                begin
                    cmd.lvl_inc = 1'b1;
                end
            end
            ST_AGE_RD:
            begin
                cmd.lvl_sel = mlqas_pkg::LVL_NEXT;
                cmd.pop     = 1'b1;
                state_next  = ST_AGE_WR;
            end
            ST_AGE_WR:
            begin
                cmd.push_rd = 1'b1;
                cmd.lvl_inc = 1'b1;
                state_next  = ST_AGE_CHK;
            end
            // re-queue the given process
            ST_PUSH:
            begin
                cmd.lvl_sel = mlqas_pkg::LVL_PRIO;
                cmd.push_id = 1'b1;
                state_next  = (status.op == mlqas_pkg::OP_SCHED) ? ST_PICK : ST_IDLE;
            end
            ST_PICK:
            begin
                cmd.lvl_sel   = mlqas_pkg::LVL_FIRST;
                cmd.pop       = 1'b1;
                cmd.pick_mark = 1'b1;
                state_next    = ST_SEND;
            end
            ST_SEND:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            // removal: compact one level, then move on
            ST_RM_RD:
            begin
                if (status.rm_done)
                begin
                    cmd.rm_commit = 1'b1;
                    if (status.last_lvl)
                    begin
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        cmd.lvl_inc = 1'b1;
                        cmd.rm_init = 1'b1;
                    end
                end
                else
                begin
                    cmd.rm_rd  = 1'b1;
                    state_next = ST_RM_CHK;
                end
            end
            ST_RM_CHK:
            begin
                cmd.rm_chk = 1'b1;
                state_next = ST_RM_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/mlqas_datapath.sv
// ----------------------------------------------------------------------------
// mlqas_datapath
// Queue storage, per-level head and count registers, removal cursors and
// the result register of the scheduler.
// ----------------------------------------------------------------------------
module mlqas_datapath #(
    parameter int NUM_PROCESSES = mlqas_pkg::DEF_NUM_PROCESSES,
    parameter int NUM_LEVELS    = mlqas_pkg::DEF_NUM_LEVELS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mlqas_pkg::cmd_t              cmd,
    output mlqas_pkg::status_t           status,
    input  logic [mlqas_pkg::OP_W-1:0]   operation,
    input  logic [mlqas_pkg::ID_W-1:0]   process_id,
    input  logic                         is_ready,
    input  logic [mlqas_pkg::PRIO_W-1:0] priority_req,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic [mlqas_pkg::ID_W-1:0]   next_process
);

    localparam int PW    = $clog2(NUM_PROCESSES);
    localparam int CW    = $clog2(NUM_PROCESSES + 1);
    localparam int LW    = $clog2(NUM_LEVELS);
    localparam int DEPTH = NUM_LEVELS * NUM_PROCESSES;
    localparam int AW    = $clog2(DEPTH);

    // captured item
    logic [mlqas_pkg::OP_W-1:0]   op_reg;
    logic [mlqas_pkg::ID_W-1:0]   id_reg;
    logic                         ready_reg;
    logic [mlqas_pkg::PRIO_W-1:0] prio_reg;

    // queue control state
    logic [PW-1:0] head_reg [NUM_LEVELS];
    logic [PW-1:0] head_next [NUM_LEVELS];
    logic [CW-1:0] count_reg [NUM_LEVELS];
    logic [CW-1:0] count_next [NUM_LEVELS];
    logic [LW-1:0] lvl_reg;
    logic [CW-1:0] k_reg;
    logic [CW-1:0] n_reg;
    logic          none_reg;
    logic          out_valid_reg;
    logic [mlqas_pkg::ID_W-1:0] out_data_reg;

    logic [NUM_LEVELS-1:0] nonempty;
    logic [NUM_LEVELS-1:0] full;
    logic [LW-1:0]         lvl_next;
    logic [LW-1:0]         lvl_first;
    logic [LW-1:0]         lvl_prio;
    logic [LW-1:0]         sel_lvl;
    logic [PW-1:0]         head_sel;
    logic [CW-1:0]         count_sel;
    logic [AW-1:0]         base_addr;
    logic                  last_lvl;
    logic                  id_ok;
    logic                  pop_eff;
    logic                  push_eff;
    logic                  rm_wr;
    logic                  wr_en;
    logic                  rd_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [mlqas_pkg::ID_W-1:0] wr_data;
    logic [mlqas_pkg::ID_W-1:0] rd_data;

    // ring position of head plus offset
    function automatic logic [PW-1:0] wrap_pos(input logic [PW-1:0] head,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(off);
        if (sum >= (CW+1)'(NUM_PROCESSES))
        begin
            sum = sum - (CW+1)'(NUM_PROCESSES);
        end
        return PW'(sum);
    endfunction

    // per-level flags
    always_comb
    begin
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            nonempty[l] = (count_reg[l] != '0);
            full[l]     = (count_reg[l] == CW'(NUM_PROCESSES));
        end
    end

    // first non-empty level
    always_comb
    begin
        lvl_first = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (nonempty[l])
            begin
                lvl_first = LW'(l);
            end
        end
    end

    assign last_lvl = (lvl_reg == LW'(NUM_LEVELS - 1));
    assign lvl_next = last_lvl ? lvl_reg : lvl_reg + LW'(1);
    assign lvl_prio = (32'(prio_reg) >= 32'(NUM_LEVELS)) ? LW'(NUM_LEVELS - 1)
                                                         : LW'(prio_reg);
    assign id_ok    = (id_reg != '0) && (32'(id_reg) < 32'(NUM_PROCESSES));

    // level selection
    always_comb
    begin
        case (cmd.lvl_sel)
            mlqas_pkg::LVL_CUR:   sel_lvl = lvl_reg;
            mlqas_pkg::LVL_NEXT:  sel_lvl = lvl_next;
            mlqas_pkg::LVL_PRIO:  sel_lvl = lvl_prio;
            mlqas_pkg::LVL_FIRST: sel_lvl = lvl_first;
            default:              sel_lvl = lvl_reg;
        endcase
    end

    assign head_sel  = head_reg[sel_lvl];
    assign count_sel = count_reg[sel_lvl];
    assign base_addr = AW'(sel_lvl) * AW'(NUM_PROCESSES);

    // memory access qualifiers
    assign pop_eff  = cmd.pop && (count_sel != '0);
    assign push_eff = cmd.push_rd
                      || (cmd.push_id && ready_reg && id_ok && (count_sel != CW'(NUM_PROCESSES)));
    assign rm_wr    = cmd.rm_chk && (rd_data != id_reg);

    assign wr_en   = push_eff || rm_wr;
    assign wr_addr = base_addr + AW'(wrap_pos(head_sel, cmd.rm_chk ? n_reg : count_sel));
    assign wr_data = cmd.push_id ? id_reg : rd_data;
    assign rd_en   = pop_eff || cmd.rm_rd;
    assign rd_addr = base_addr + AW'(cmd.rm_rd ? wrap_pos(head_sel, k_reg) : head_sel);

    mlqas_ram #(
        .WIDTH (mlqas_pkg::ID_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // head and count update
    always_comb
    begin
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            head_next[l]  = head_reg[l];
            count_next[l] = count_reg[l];
            if (cmd.clear)
            begin
                head_next[l]  = '0;
                count_next[l] = '0;
            end
            else if (sel_lvl == LW'(l))
            begin
                if (pop_eff)
                begin
                    head_next[l]  = (head_reg[l] == PW'(NUM_PROCESSES - 1)) ? '0
                                                                             : head_reg[l] + PW'(1);
                    count_next[l] = count_reg[l] - CW'(1);
                end
                else if (push_eff)
                begin
                    count_next[l] = count_reg[l] + CW'(1);
                end
                else if (cmd.rm_commit)
                begin
                    count_next[l] = n_reg;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            lvl_reg       <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            none_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l]  <= head_next[l];
                count_reg[l] <= count_next[l];
            end
            if (cmd.lvl_clr)
            begin
                lvl_reg <= '0;
            end
            else if (cmd.lvl_inc)
            begin
                lvl_reg <= lvl_next;
            end
            if (cmd.rm_init)
            begin
                k_reg <= '0;
                n_reg <= '0;
            end
            else
            begin
                if (cmd.rm_rd)
                begin
                    k_reg <= k_reg + CW'(1);
                end
                if (rm_wr)
                begin
                    n_reg <= n_reg + CW'(1);
                end
            end
            if (cmd.pick_mark)
            begin
                none_reg <= (nonempty == '0);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= operation;
            id_reg    <= process_id;
            ready_reg <= is_ready;
            prio_reg  <= priority_req;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= none_reg ? '0 : rd_data;
        end
    end

    // status back to the sequencer
    always_comb
    begin
        status.op            = op_reg;
        status.id_ok         = id_ok;
        status.last_lvl      = last_lvl;
        status.nonempty_next = nonempty[lvl_next];
        status.full_cur      = full[lvl_reg];
        status.rm_done       = (k_reg == count_reg[lvl_reg]);
        status.out_free      = !out_valid_reg || !out_stall;
    end

    assign out_valid    = out_valid_reg;
    assign next_process = out_data_reg;

endmodule

>>> hdl/multilevel_queue_aging_scheduler_unit.sv
// ----------------------------------------------------------------------------
// multilevel_queue_aging_scheduler_unit
// Multilevel FIFO ready-queue scheduler with aging: schedule, slot reset and
// clear items over one queue per priority level, level 0 highest.
//
//   channel | signals                                            | direction
//   --------+----------------------------------------------------+----------
//   in      | in_valid, in_stall, operation, process_id,         | to block
//           | is_ready, priority_req                             |
//   out     | out_valid, out_stall, next_process                 | from block
//
// one item at a time; the sequencer walks the levels one step at a time over
// a queue memory with one read port and one write port
// schedule: ages each level pair, re-queues, picks, waits for the result slot
// slot reset: removes the id from every level, re-queues it; an idle id is skipped
// clear empties every queue; reset empties every queue at once, no clearing pass
// a held result does not block the next item until its pick must be stored
// ----------------------------------------------------------------------------
module multilevel_queue_aging_scheduler_unit #(
    parameter int NUM_PROCESSES = mlqas_pkg::DEF_NUM_PROCESSES,
    parameter int NUM_LEVELS    = mlqas_pkg::DEF_NUM_LEVELS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [mlqas_pkg::OP_W-1:0]   operation,
    input  logic [mlqas_pkg::ID_W-1:0]   process_id,
    input  logic                         is_ready,
    input  logic [mlqas_pkg::PRIO_W-1:0] priority_req,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [mlqas_pkg::ID_W-1:0]   next_process
);

    mlqas_pkg::cmd_t    cmd;
    mlqas_pkg::status_t status;

    // sequencer
    mlqas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // queues and result register
    mlqas_datapath #(
        .NUM_PROCESSES (NUM_PROCESSES),
        .NUM_LEVELS    (NUM_LEVELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .operation    (operation),
        .process_id   (process_id),
        .is_ready     (is_ready),
        .priority_req (priority_req),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .next_process (next_process)
    );

endmodule

>>> hdl/mlqas_checker.sv
// ----------------------------------------------------------------------------
// mlqas_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module mlqas_checker #(
    parameter int NUM_PROCESSES = mlqas_pkg::DEF_NUM_PROCESSES
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [mlqas_pkg::ID_W-1:0] next_process
);

    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(next_process))
    else $error("held result changed");

    // an accepted item keeps the block busy for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("item accepted back to back");

    // a picked process is idle or a valid slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(next_process) < 32'(NUM_PROCESSES))
    else $error("picked id out of range");

    // a new result only appears while an item is being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result without work");

endmodule

bind multilevel_queue_aging_scheduler_unit mlqas_checker #(
    .NUM_PROCESSES (NUM_PROCESSES)
) u_mlqas_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .next_process (next_process)
);
